/* rtl/core/pphd_pkg.sv */
// ----------------------------------------------------------------------------
// pphd_pkg
// Shared constants and types for the position PID H-bridge drive.
// ----------------------------------------------------------------------------
package pphd_pkg;

  localparam int unsigned COUNTS_PER_REV = 960;

  // target counts in Q.8 = |deg| * CONV_QUOT + floor(|deg| * CONV_REM / 360)
  localparam int unsigned CONV_SCALE = COUNTS_PER_REV * 256;
  localparam logic [15:0] CONV_QUOT  = 16'(CONV_SCALE / 360);
  localparam logic [8:0]  CONV_REM   = 9'(CONV_SCALE % 360);

  // floor(y / 360) = (y * RECIP_360) >> RECIP_SHIFT for every 24-bit y
  localparam int unsigned RECIP_SHIFT = 33;
  localparam logic [24:0] RECIP_360   = 25'(((64'd1 << RECIP_SHIFT) + 64'd359) / 64'd360);

  localparam logic signed [31:0] DEADBAND_Q8   = 32'sd12800;
  localparam logic signed [55:0] OUT_LIMIT_Q16 = 56'sd3932160;
  localparam logic signed [64:0] TERM_LIMIT    = 65'sd1 <<< 52;
  localparam logic [5:0]         STOP_COMPARE  = 6'd2;

  typedef enum logic [1:0] {
    CFG_GAIN_P = 2'd0,
    CFG_GAIN_I = 2'd1,
    CFG_GAIN_D = 2'd2
  } cfg_idx_e;

endpackage

/* rtl/core/position_pid_hbridge_drive.sv */
// ----------------------------------------------------------------------------
// position_pid_hbridge_drive
// Position PID with deadband and output clamp driving one of four H-bridges.
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | tuser: motor; tdata: position_counts, target_degrees
//  m_axis    | out       | tuser: motor_sel; tdata: pin_a, pin_b, pwm_compare
//  cfg       | in        | cfg_index_i selects gain_p / gain_i / gain_d
//
//  One beat per cycle while m_axis does not stall; each beat reaches m_axis
//  through six register stages (input, two target conversion multiplies,
//  error and PID state update, gain multiplies, sum). The shared
//  error_sum / last_error state is updated once per beat as it enters the
//  state-update stage. Reset clears gains, state and valid bits. Each stage
//  holds under backpressure and empty stages fill while m_axis stalls.
// ----------------------------------------------------------------------------
module position_pid_hbridge_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] position_counts, [31:16] target_degrees
  input  logic [1:0]  s_axis_tuser,   // [1:0] motor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] pin_a, [1] pin_b, [7:2] pwm_compare
  output logic [1:0]  m_axis_tuser,   // [1:0] motor_sel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pphd_pkg::*;

  logic [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [47:0] error_sum_q;
  logic signed [31:0] last_error_q;

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [1:0] mot0_q, mot1_q, mot2_q, mot3_q, mot4_q, mot5_q;
  logic signed [15:0] pos0_q, pos1_q, pos2_q;
  logic signed [15:0] tgt0_q;
  logic neg1_q, neg2_q;
  logic [31:0] tq1_q, tq2_q;
  logic [23:0] tr1_q;
  logic [15:0] q2_q;
  logic signed [31:0] err3_q;
  logic signed [47:0] sum3_q;
  logic signed [32:0] diff3_q;
  logic dead3_q, dead4_q;
  logic signed [48:0] p4_q;
  logic signed [53:0] i4_q;
  logic signed [49:0] d4_q;
  logic pa5_q, pb5_q;
  logic [5:0] cmp5_q;

  // handshake chain
  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;
  assign cfg_ready_o   = 1'b1;

  logic load3;
  assign load3 = v2_q && rdy3;

  // stage 1: target magnitude times scale, split into quotient and remainder
  logic [15:0] tabs;
  logic [31:0] tq1_d;
  logic [23:0] tr1_d;
  assign tabs  = tgt0_q[15] ? 16'(-tgt0_q) : 16'(tgt0_q);
  assign tq1_d = 32'(tabs) * 32'(CONV_QUOT);
  assign tr1_d = 24'(tabs) * 24'(CONV_REM);

  // stage 2: remainder part divided by 360
  logic [48:0] recip_prod;
  assign recip_prod = 49'(tr1_q) * 49'(RECIP_360);

  // stage 3: error, integral and difference
  logic [32:0]        tmag;
  logic signed [33:0] tsig;
  logic signed [34:0] err_wide;
  logic signed [31:0] err_d;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_d;
  logic signed [32:0] diff_d;
  logic               dead_d;

  always_comb begin
    tmag     = {1'b0, tq2_q} + {17'b0, q2_q};
    tsig     = neg2_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    err_wide = 35'(tsig) - (35'(pos2_q) <<< 8);
    if (err_wide[34:31] == 4'b0000 || err_wide[34:31] == 4'b1111) begin
      err_d = err_wide[31:0];
    end else if (err_wide[34]) begin
      err_d = {1'b1, 31'b0};
    end else begin
      err_d = {1'b0, {31{1'b1}}};
    end
    sum_wide = 49'(error_sum_q) + 49'(err_d);
    if (sum_wide[48] == sum_wide[47]) begin
      sum_d = sum_wide[47:0];
    end else if (sum_wide[48]) begin
      sum_d = {1'b1, 47'b0};
    end else begin
      sum_d = {1'b0, {47{1'b1}}};
    end
    diff_d = 33'(err_d) - 33'(last_error_q);
    dead_d = (err_d < DEADBAND_Q8) && (err_d > -DEADBAND_Q8);
  end

  // stage 4: gain products
  logic signed [48:0] p4_d;
  logic signed [64:0] iprod;
  logic signed [53:0] i4_d;
  logic signed [49:0] d4_d;

  always_comb begin
    p4_d  = 49'($signed({1'b0, gain_p_q})) * 49'(err3_q);
    iprod = 65'($signed({1'b0, gain_i_q})) * 65'(sum3_q);
    d4_d  = 50'($signed({1'b0, gain_d_q})) * 50'(diff3_q);
    if (iprod > TERM_LIMIT) begin
      i4_d = 54'(TERM_LIMIT);
    end else if (iprod < -TERM_LIMIT) begin
      i4_d = 54'(-TERM_LIMIT);
    end else begin
      i4_d = iprod[53:0];
    end
  end

  // stage 5: sum, clamp, truncate toward zero, bridge pins
  logic signed [55:0] total;
  logic signed [55:0] clamped;
  logic [55:0]        mag;
  logic [5:0]         speed_mag;
  logic               stop;
  logic               pa5_d, pb5_d;
  logic [5:0]         cmp5_d;

  always_comb begin
    total = 56'(p4_q) + 56'(i4_q) + 56'(d4_q);
    if (total > OUT_LIMIT_Q16) begin
      clamped = OUT_LIMIT_Q16;
    end else if (total < -OUT_LIMIT_Q16) begin
      clamped = -OUT_LIMIT_Q16;
    end else begin
      clamped = total;
    end
    mag       = clamped[55] ? 56'(-clamped) : 56'(clamped);
    speed_mag = mag[21:16];
    stop      = dead4_q || (speed_mag == 6'd0);
    pa5_d     = stop || clamped[55];
    pb5_d     = !stop && !clamped[55];
    cmp5_d    = stop ? STOP_COMPARE : speed_mag;
  end

  // control: valid bits, gains, PID state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      v5_q         <= 1'b0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (load3) begin
        error_sum_q  <= sum_d;
        last_error_q <= err_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GAIN_P: gain_p_q <= cfg_data_i;
          CFG_GAIN_I: gain_i_q <= cfg_data_i;
          CFG_GAIN_D: gain_d_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      mot0_q <= s_axis_tuser;
      pos0_q <= s_axis_tdata[15:0];
      tgt0_q <= s_axis_tdata[31:16];
    end
    if (rdy1 && v0_q) begin
      mot1_q <= mot0_q;
      pos1_q <= pos0_q;
      neg1_q <= tgt0_q[15];
      tq1_q  <= tq1_d;
      tr1_q  <= tr1_d;
    end
    if (rdy2 && v1_q) begin
      mot2_q <= mot1_q;
      pos2_q <= pos1_q;
      neg2_q <= neg1_q;
      tq2_q  <= tq1_q;
      q2_q   <= recip_prod[48:33];
    end
    if (load3) begin
      mot3_q  <= mot2_q;
      err3_q  <= err_d;
      sum3_q  <= sum_d;
      diff3_q <= diff_d;
      dead3_q <= dead_d;
    end
    if (rdy4 && v3_q) begin
      mot4_q  <= mot3_q;
      p4_q    <= p4_d;
      i4_q    <= i4_d;
      d4_q    <= d4_d;
      dead4_q <= dead3_q;
    end
    if (rdy5 && v4_q) begin
      mot5_q <= mot4_q;
      pa5_q  <= pa5_d;
      pb5_q  <= pb5_d;
      cmp5_q <= cmp5_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tuser  = mot5_q;
  assign m_axis_tdata  = {cmp5_q, pb5_q, pa5_q};

  a_pins_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(pa5_q && pb5_q) && (pa5_q || pb5_q))
    else $error("bridge pins not exclusive");

  a_compare_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cmp5_q != 6'd0) && (cmp5_q <= 6'd60))
    else $error("pwm compare out of range");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load3 |=> $stable(error_sum_q) && $stable(last_error_q))
    else $error("PID state changed without a beat");

  a_forward_not_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy5 && v4_q && dead4_q) |=> pa5_q && (cmp5_q == STOP_COMPARE))
    else $error("deadband beat did not stop the bridge");

endmodule

/* test/position_pid_hbridge_drive_tb.sv */
// ----------------------------------------------------------------------------
// position_pid_hbridge_drive_tb
// Self-checking bench for the position PID H-bridge drive. Setpoint beats go
// in on s_axis. Each accepted beat runs through a bit-accurate PID model that
// has its own gains and integral/derivative state. The drive words that come
// out on m_axis are compared, field by field and in order, with the model's
// values. Gains are reprogrammed between phases while the pipeline is empty,
// and the phases cycle through three patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module position_pid_hbridge_drive_tb;
  import pphd_pkg::*;

  localparam longint      ERR_HI          = 64'sd2147483647;
  localparam longint      ERR_LO          = -64'sd2147483648;
  localparam longint      SUM_HI          = (64'sd1 <<< 47) - 64'sd1;
  localparam longint      SUM_LO          = -SUM_HI - 64'sd1;
  localparam longint      DEAD_ZONE_Q8    = 64'sd12800;
  localparam longint      DRIVE_CAP_Q16   = 64'sd60 * 64'sd65536;
  localparam logic [63:0] TERM_CAP        = 64'd1 << 52;
  localparam logic [5:0]  STOP_CMP        = 6'd2;
  localparam logic [1:0]  CFG_SPARE       = 2'd3;
  localparam int          ITEMS_PER_PHASE = 94;
  localparam int          NUM_PHASES      = 8;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          MAX_CYCLES      = 200000;

  typedef struct packed {
    logic [1:0] motor;
    logic       pin_a;
    logic       pin_b;
    logic [5:0] compare;
  } drive_t;

  class hbridge_drive_checker;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    longint      error_sum;
    longint      last_error;
    drive_t      pending_drives[$];
    int          mismatches;

    function new();
      gain_p     = '0;
      gain_i     = '0;
      gain_d     = '0;
      error_sum  = 0;
      last_error = 0;
      mismatches = 0;
    endfunction

    function void write_gain(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_GAIN_P: gain_p = val;
        CFG_GAIN_I: gain_i = val;
        CFG_GAIN_D: gain_d = val;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint gain_term(logic [15:0] gain, longint x);
      logic [63:0] mag;
      logic [63:0] prod;
      mag  = (x < 0) ? 64'(-x) : 64'(x);
      prod = mag * {48'd0, gain};
      if (prod > TERM_CAP) prod = TERM_CAP;
      return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function void take_setpoint(logic [1:0] motor, logic signed [15:0] pos,
                                logic signed [15:0] tgt);
      longint tgt_q8;
      longint err;
      longint diff;
      longint drive;
      longint speed;
      drive_t want;
      tgt_q8 = (longint'(tgt) * longint'(COUNTS_PER_REV) * 64'sd256) / 64'sd360;
      err    = clip(tgt_q8 - longint'(pos) * 64'sd256, ERR_LO, ERR_HI);
      error_sum  = clip(error_sum + err, SUM_LO, SUM_HI);
      diff       = err - last_error;
      last_error = err;
      drive = gain_term(gain_p, err) + gain_term(gain_i, error_sum)
            + gain_term(gain_d, diff);
      drive = clip(drive, -DRIVE_CAP_Q16, DRIVE_CAP_Q16);
      if (err < DEAD_ZONE_Q8 && err > -DEAD_ZONE_Q8) speed = 0;
      else speed = drive / 64'sd65536;
      want.motor = motor;
      if (speed > 0) begin
        want.pin_a   = 1'b0;
        want.pin_b   = 1'b1;
        want.compare = 6'(speed);
      end else if (speed < 0) begin
        want.pin_a   = 1'b1;
        want.pin_b   = 1'b0;
        want.compare = 6'(-speed);
      end else begin
        want.pin_a   = 1'b1;
        want.pin_b   = 1'b0;
        want.compare = STOP_CMP;
      end
      pending_drives.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch on %s: got %0d want %0d", what, got, want);
    endtask

    task check_drive(logic [1:0] tuser, logic [7:0] tdata);
      drive_t want;
      if (pending_drives.size() == 0) begin
        report_mismatch("unexpected beat", int'(tdata), 0);
        return;
      end
      want = pending_drives.pop_front();
      if (tuser !== want.motor) report_mismatch("motor_sel", int'(tuser), int'(want.motor));
      if (tdata[0] !== want.pin_a) report_mismatch("pin_a", int'(tdata[0]), int'(want.pin_a));
      if (tdata[1] !== want.pin_b) report_mismatch("pin_b", int'(tdata[1]), int'(want.pin_b));
      if (tdata[7:2] !== want.compare)
        report_mismatch("pwm_compare", int'(tdata[7:2]), int'(want.compare));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int cycle_count   = 0;

  hbridge_drive_checker drive_check = new();

  position_pid_hbridge_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      drive_check.check_drive(m_axis_tuser, m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void set_idling(int mode);
    case (mode)
      0: begin
        src_idle_pct   = 20;
        sink_stall_pct = 62;
      end
      1: begin
        src_idle_pct   = 62;
        sink_stall_pct = 20;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    drive_check.write_gain(idx, val);
  endtask

  task automatic program_gains(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd);
    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_setpoint(input logic [1:0] motor, input logic [15:0] pos,
                               input logic [15:0] tgt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= motor;
    s_axis_tdata  <= {tgt, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    drive_check.take_setpoint(motor, pos, tgt);
  endtask

  task automatic send_random_setpoint();
    int          kind;
    int          tgt;
    int          nominal;
    int          offset;
    logic [15:0] pos_w;
    logic [15:0] tgt_w;
    kind = $urandom_range(99);
    if (kind < 10) begin
      pos_w = 16'($urandom);
      tgt_w = 16'($urandom);
    end else begin
      // land the position near the converted target: around the dead zone edge,
      // anywhere from inside it to well outside it, or inside it
      tgt     = int'($urandom_range(1440)) - 720;
      nominal = (tgt * 8) / 3;
      if (kind < 50) offset = int'($urandom_range(70, 40));
      else if (kind < 85) offset = int'($urandom_range(600));
      else offset = int'($urandom_range(40));
      if ($urandom_range(1) == 1) offset = -offset;
      pos_w = 16'(nominal + offset);
      tgt_w = 16'(tgt);
    end
    send_setpoint(2'($urandom_range(3)), pos_w, tgt_w);
  endtask

  task automatic drain_pipeline();
    while (drive_check.pending_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    program_gains(16'd256, 16'd0, 16'd0);
    send_setpoint(2'd0, 16'd0, 16'd0);
    send_setpoint(2'd1, -16'sd50, 16'd0);
    send_setpoint(2'd2, -16'sd49, 16'd0);
    send_setpoint(2'd3, 16'd50, 16'd0);
    send_setpoint(2'd0, 16'd49, 16'd0);
    send_setpoint(2'd1, 16'd0, 16'd1);
    send_setpoint(2'd2, 16'd0, -16'sd1);
    send_setpoint(2'd3, 16'h8000, 16'h7fff);
    send_setpoint(2'd0, 16'h7fff, 16'h8000);
    send_setpoint(2'd1, 16'h7fff, 16'h7fff);
    send_setpoint(2'd2, 16'h8000, 16'h8000);
    send_setpoint(2'd3, 16'd0, 16'd19);
    send_setpoint(2'd0, 16'd0, -16'sd19);
    send_setpoint(2'd1, -16'sd60, 16'd0);
    send_setpoint(2'd2, -16'sd61, 16'd0);
    send_setpoint(2'd3, 16'd61, 16'd0);
    send_setpoint(2'd0, 16'd60, 16'd0);
    send_setpoint(2'd1, 16'h8000, 16'd0);
    send_setpoint(2'd2, 16'h7fff, 16'd0);
    send_setpoint(2'd3, 16'd0, 16'h7fff);
    send_setpoint(2'd0, 16'd0, 16'h8000);
    s_axis_tvalid <= 1'b0;
    drain_pipeline();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_idling(ph % 3);
      case (ph)
        0: program_gains(16'd0, 16'd0, 16'd0);
        1: program_gains(16'd16, 16'd0, 16'd8);
        2: program_gains(16'hffff, 16'hffff, 16'hffff);
        3: program_gains(16'd64, 16'd1, 16'd32);
        4: program_gains(16'd256, 16'd0, 16'd0);
        5: program_gains(16'd4, 16'd0, 16'd128);
        default: program_gains(16'($urandom_range(300)), 16'($urandom_range(2)),
                               16'($urandom_range(300)));
      endcase
      repeat (ITEMS_PER_PHASE) send_random_setpoint();
      s_axis_tvalid <= 1'b0;
      drain_pipeline();
    end

    if (drive_check.mismatches == 0 && drive_check.pending_drives.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
